FILE: design/m4vt_pkg.sv
// Shared types and constants for the 4x4 matrix by vector transform.
package m4vt_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 12;
  localparam int ENTRY_W   = 16;
  localparam int DATA_W    = 32;
  localparam int ROW_W     = DIM * ENTRY_W;
  localparam int PROD_W    = ENTRY_W + DATA_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SH_W      = SUM_W - FRAC_BITS;
  localparam int CFG_IDX_W = 8;

  localparam logic CMD_XYZW = 1'b0;
  localparam logic CMD_XYZ  = 1'b1;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [DIM-1:0][DATA_W-1:0] vec_t;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] vec_z;
    logic signed [DATA_W-1:0] vec_w;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic signed [DATA_W-1:0] out_w;
    logic                     saturated;
  } out_t;

  // Identity row: one in Q4.12 on the diagonal.
  function automatic row_t identity_row(input int r);
    row_t v;
    v = '0;
    v[r*ENTRY_W +: ENTRY_W] = ENTRY_W'(1 << FRAC_BITS);
    return v;
  endfunction

endpackage

FILE: design/m4vt_lane.sv
// One row lane: products of a matrix row with the vector, then round and saturate.
module m4vt_lane (
  input  logic                             clk,
  input  m4vt_pkg::row_t                   row,
  input  m4vt_pkg::vec_t                   vec,
  input  logic                             use_w,
  output logic signed [m4vt_pkg::DATA_W-1:0] comp,
  output logic                             sat
);
  import m4vt_pkg::*;

  logic signed [PROD_W-1:0] prod_r [DIM];
  logic signed [PROD_W-1:0] prod_nxt [DIM];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SH_W-1:0]   shifted;
  logic signed [DATA_W-1:0] comp_r, comp_nxt;
  logic                     sat_r, sat_nxt;

  localparam logic signed [SUM_W-1:0] RND =
    (FRAC_BITS > 0) ? SUM_W'(1) <<< (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0) : '0;
  localparam logic signed [SH_W-1:0] MAX_V = SH_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [SH_W-1:0] MIN_V = -MAX_V - SH_W'(1);

  // Stage one: one multiplier per column.
  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      if (c == DIM - 1 && !use_w) begin
        prod_nxt[c] = '0;
      end else begin
        prod_nxt[c] = PROD_W'($signed(row[c*ENTRY_W +: ENTRY_W])) *
                      PROD_W'($signed(vec[c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Stage two: add, round half up, clamp.
  always_comb begin
    sum = RND;
    for (int c = 0; c < DIM; c++) begin
      sum = sum + {{(SUM_W-PROD_W){prod_r[c][PROD_W-1]}}, prod_r[c]};
    end
    shifted = SH_W'(sum >>> FRAC_BITS);
    if (shifted > MAX_V) begin
      comp_nxt = MAX_V[DATA_W-1:0];
      sat_nxt  = 1'b1;
    end else if (shifted < MIN_V) begin
      comp_nxt = MIN_V[DATA_W-1:0];
      sat_nxt  = 1'b1;
    end else begin
      comp_nxt = shifted[DATA_W-1:0];
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    comp_r <= comp_nxt;
    sat_r  <= sat_nxt;
  end

  assign comp = comp_r;
  assign sat  = sat_r;

endmodule

FILE: design/matrix4x4_vector_transform.sv
// Top level: matrix registers, four row lanes and the merging output stage.
// A result strobes out_valid after the lane product, lane clamp and output registers.
// Throughput: one item per cycle; busy stays low, the lanes are fully pipelined.
// Each lane has one 16x32 multiplier stage, then one add/round/clamp stage.
// Reset (rst_n low, synchronous) sets the matrix to identity and clears the valid flags.
// Results cannot be stalled: each is on out_data for exactly one cycle.
module matrix4x4_vector_transform (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  m4vt_pkg::in_t                    in_data,
  output logic                             out_valid,
  output m4vt_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [m4vt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [m4vt_pkg::ROW_W-1:0]       cfg_data
);
  import m4vt_pkg::*;

  row_t                     mat_r [DIM];
  vec_t                     vec;
  logic                     accept;
  logic                     use_w;
  logic signed [DATA_W-1:0] comp [DIM];
  logic                     sat [DIM];
  logic                     v1_r, v2_r, out_valid_r;
  logic                     cmd1_r, cmd2_r, cmd3_r;
  out_t                     out_r, out_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign use_w     = (in_data.cmd == CMD_XYZW);

  assign vec[0] = in_data.vec_x;
  assign vec[1] = in_data.vec_y;
  assign vec[2] = in_data.vec_z;
  assign vec[3] = in_data.vec_w;

  always_ff @(posedge clk) begin
    for (int r = 0; r < DIM; r++) begin
      if (!rst_n) begin
        mat_r[r] <= identity_row(r);
      end else if (cfg_valid && cfg_ready && cfg_index == CFG_IDX_W'(r)) begin
        mat_r[r] <= cfg_data;
      end
    end
  end

  for (genvar r = 0; r < DIM; r++) begin : g_lane
    m4vt_lane u_lane (
      .clk   (clk),
      .row   (mat_r[r]),
      .vec   (vec),
      .use_w (use_w),
      .comp  (comp[r]),
      .sat   (sat[r])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r <= in_data.cmd;
    cmd2_r <= cmd1_r;
    cmd3_r <= cmd2_r;
  end

  // Merge: drop the w lane in the three-component form, OR the clamp flags.
  always_comb begin
    out_nxt.out_x = comp[0];
    out_nxt.out_y = comp[1];
    out_nxt.out_z = comp[2];
    if (cmd2_r == CMD_XYZ) begin
      out_nxt.out_w     = '0;
      out_nxt.saturated = sat[0] | sat[1] | sat[2];
    end else begin
      out_nxt.out_w     = comp[3];
      out_nxt.saturated = sat[0] | sat[1] | sat[2] | sat[3];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy) |-> ##3 out_valid)
    else $error("result did not appear three cycles after start");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without a matching start transfer");

  a_xyz_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cmd3_r == CMD_XYZ) |-> (out_data.out_w == '0))
    else $error("w component not zero in three-component form");

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.saturated) |->
      (out_data.out_x != {1'b0, {(DATA_W-1){1'b1}}} || $past(!sat[0])))
    else $error("saturation flag lost for x component");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the 4x4 fixed-point matrix by vector transform.
module tb;
  import m4vt_pkg::*;

  localparam int  LATENCY     = 3;
  localparam int  CYCLE_LIMIT = 300000;
  localparam int  MAX_REPORTS = 40;
  localparam int  PHASES      = 13;
  localparam int  PHASE_ITEMS = 100;
  localparam logic [DATA_W-1:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] W_MIN = 32'h8000_0000;
  localparam longint POS_LIMIT = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint NEG_LIMIT = -(longint'(1) <<< (DATA_W - 1));

  typedef enum {ROW_RANDOM, ROW_UNIT, ROW_EXTREME, ROW_IDENTITY} row_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  row_t cfg_data = '0;

  row_t mat_rows [DIM];
  out_t transformed_q [$];
  int mismatches = 0;
  int cycle_count = 0;

  matrix4x4_vector_transform u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Row dot vector, rounded half up, clamped to 32 bits.
  function automatic out_t transform_vector(in_t item);
    logic signed [DATA_W-1:0] comp [DIM];
    logic signed [ENTRY_W-1:0] coef;
    longint acc;
    longint lanes [DIM];
    int terms;
    out_t res;
    comp[0] = item.vec_x;
    comp[1] = item.vec_y;
    comp[2] = item.vec_z;
    comp[3] = item.vec_w;
    terms = (item.cmd == CMD_XYZ) ? 3 : 4;
    res = '0;
    for (int r = 0; r < DIM; r++) begin
      acc = 0;
      for (int c = 0; c < terms; c++) begin
        coef = mat_rows[r][c*ENTRY_W +: ENTRY_W];
        acc += longint'(coef) * longint'(comp[c]);
      end
      lanes[r] = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r >= terms) begin
        lanes[r] = 0;
      end else if (lanes[r] > POS_LIMIT) begin
        lanes[r] = POS_LIMIT;
        res.saturated = 1'b1;
      end else if (lanes[r] < NEG_LIMIT) begin
        lanes[r] = NEG_LIMIT;
        res.saturated = 1'b1;
      end
    end
    res.out_x = lanes[0][DATA_W-1:0];
    res.out_y = lanes[1][DATA_W-1:0];
    res.out_z = lanes[2][DATA_W-1:0];
    res.out_w = lanes[3][DATA_W-1:0];
    return res;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (transformed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result expected none actual %h", $time, out_data);
        end else begin
          want = transformed_q.pop_front();
          check_field("out_x", want.out_x, out_data.out_x);
          check_field("out_y", want.out_y, out_data.out_y);
          check_field("out_z", want.out_z, out_data.out_z);
          check_field("out_w", want.out_w, out_data.out_w);
          check_field("saturated", DATA_W'(want.saturated), DATA_W'(out_data.saturated));
        end
      end
      if (start && !busy)
        transformed_q.push_back(transform_vector(in_data));
    end
  end

  function automatic logic [DATA_W-1:0] rand_component();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 'h40000) - 'h20000;
      1: begin
        case ($urandom_range(0, 4))
          0: return W_MAX;
          1: return W_MIN;
          2: return '0;
          3: return '1;
          default: return 32'd1;
        endcase
      end
      2: return ($urandom_range(0, 'hFFFF) << FRAC_BITS) + $urandom_range(2046, 2050);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t item;
    item.cmd   = ($urandom_range(0, 1) == 0) ? CMD_XYZW : CMD_XYZ;
    item.vec_x = rand_component();
    item.vec_y = rand_component();
    item.vec_z = rand_component();
    item.vec_w = rand_component();
    return item;
  endfunction

  function automatic in_t make_item(logic cmd, logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                                   logic [DATA_W-1:0] z, logic [DATA_W-1:0] w);
    in_t item;
    item.cmd   = cmd;
    item.vec_x = x;
    item.vec_y = y;
    item.vec_z = z;
    item.vec_w = w;
    return item;
  endfunction

  function automatic row_t unit_row(int r);
    return row_t'(1 << FRAC_BITS) << (r * ENTRY_W);
  endfunction

  function automatic row_t rand_row(row_kind_t kind, int r);
    row_t row;
    for (int c = 0; c < DIM; c++) begin
      case (kind)
        ROW_RANDOM:  row[c*ENTRY_W +: ENTRY_W] = ENTRY_W'($urandom);
        ROW_UNIT:    row[c*ENTRY_W +: ENTRY_W] =
                       ENTRY_W'($urandom_range(0, 'h2000) - 'h1000);
        ROW_EXTREME: begin
          case ($urandom_range(0, 2))
            0: row[c*ENTRY_W +: ENTRY_W] = 16'h7FFF;
            1: row[c*ENTRY_W +: ENTRY_W] = 16'h8000;
            default: row[c*ENTRY_W +: ENTRY_W] = 16'h0000;
          endcase
        end
        default: row[c*ENTRY_W +: ENTRY_W] = (c == r) ? 16'(1 << FRAC_BITS) : 16'h0000;
      endcase
    end
    return row;
  endfunction

  // Hold start low until the pipeline has drained.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (transformed_q.size() != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic cfg_write(int idx, row_t value);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < DIM)
      mat_rows[idx] = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_matrix(row_t r0, row_t r1, row_t r2, row_t r3);
    wait_idle();
    cfg_write(0, r0);
    cfg_write(1, r1);
    cfg_write(2, r2);
    cfg_write(3, r3);
  endtask

  // Present one vector after an idle gap; return once the transfer is taken.
  task automatic send_vec(in_t item, int gap);
    if (gap > 0) begin
      start   <= 1'b0;
      in_data <= rand_item();
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic test_identity_reset();
    send_vec(make_item(CMD_XYZW, W_MAX, W_MIN, '0, '1), 0);
    send_vec(make_item(CMD_XYZW, W_MIN, W_MAX, 32'd1, W_MAX), 0);
    send_vec(make_item(CMD_XYZ, W_MAX, W_MIN, '1, W_MIN), $urandom_range(0, 6));
    send_vec(make_item(CMD_XYZ, '0, 32'd1, W_MAX, 32'h1234_5678), 0);
  endtask

  // One LSB of Q4.12 on the diagonal exposes the half-up rounding.
  task automatic test_rounding();
    load_matrix(row_t'(16'h0001), row_t'(16'h0001) << 16, row_t'(16'h0001) << 32,
                row_t'(16'h0001) << 48);
    send_vec(make_item(CMD_XYZW, 32'd2048, -32'sd2048, 32'd2047, -32'sd2049), 0);
    send_vec(make_item(CMD_XYZW, 32'd6144, -32'sd6144, W_MAX, W_MIN), $urandom_range(0, 6));
  endtask

  task automatic test_saturation();
    load_matrix({DIM{16'h7FFF}}, {DIM{16'h7FFF}}, {DIM{16'h7FFF}}, {DIM{16'h7FFF}});
    send_vec(make_item(CMD_XYZW, W_MAX, W_MAX, W_MAX, W_MAX), 0);
    send_vec(make_item(CMD_XYZW, W_MIN, W_MIN, W_MIN, W_MIN), 0);
    send_vec(make_item(CMD_XYZ, W_MAX, W_MAX, W_MAX, W_MIN), 0);
    // Only the w row would clamp: the short form must leave the flag clear.
    load_matrix('0, '0, '0, {DIM{16'h8000}});
    send_vec(make_item(CMD_XYZ, W_MIN, W_MIN, W_MIN, W_MIN), $urandom_range(0, 6));
    send_vec(make_item(CMD_XYZW, W_MIN, W_MIN, W_MIN, W_MIN), 0);
  endtask

  task automatic test_xyz_form();
    in_t item;
    load_matrix(rand_row(ROW_UNIT, 0), rand_row(ROW_UNIT, 1), rand_row(ROW_UNIT, 2),
                rand_row(ROW_RANDOM, 3));
    item = make_item(CMD_XYZ, rand_component(), rand_component(), rand_component(), W_MAX);
    send_vec(item, 0);
    item.cmd = CMD_XYZW;
    send_vec(item, 0);
  endtask

  // Writes past the last row register must leave the matrix alone.
  task automatic test_bad_index();
    load_matrix(unit_row(0), unit_row(1), unit_row(2), unit_row(3));
    cfg_write(DIM, {DIM{16'h7FFF}});
    cfg_write((1 << CFG_IDX_W) - 1, {$urandom, $urandom});
    send_vec(make_item(CMD_XYZW, 32'h0001_8000, W_MIN, W_MAX, -32'sd77), 0);
    send_vec(make_item(CMD_XYZ, W_MAX, 32'd5, W_MIN, W_MAX), $urandom_range(0, 6));
  endtask

  // Stream the columns of a right-hand matrix; each result is a product column.
  task automatic test_matrix_product();
    load_matrix(rand_row(ROW_UNIT, 0), rand_row(ROW_UNIT, 1), rand_row(ROW_UNIT, 2),
                rand_row(ROW_UNIT, 3));
    for (int c = 0; c < DIM; c++)
      send_vec(make_item(CMD_XYZW, rand_component(), rand_component(), rand_component(),
                         rand_component()), 0);
  endtask

  task automatic test_random();
    bit burst;
    int gap;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      for (int r = 0; r < DIM; r++)
        cfg_write(r, rand_row(row_kind_t'($urandom_range(0, 3)), r));
      if ($urandom_range(0, 2) == 0)
        cfg_write($urandom_range(DIM, (1 << CFG_IDX_W) - 1), {$urandom, $urandom});
      burst = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 63) == 0)
          wait_idle();
        if (burst || $urandom_range(0, 3) == 0)
          gap = 0;
        else
          gap = $urandom_range(0, 6);
        send_vec(rand_item(), gap);
      end
    end
  endtask

  initial begin
    for (int r = 0; r < DIM; r++)
      mat_rows[r] = unit_row(r);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_identity_reset();
    test_rounding();
    test_saturation();
    test_xyz_form();
    test_bad_index();
    test_matrix_product();
    test_random();
    wait_idle();
    if (mismatches == 0 && transformed_q.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
